// ----- rtl/alte_pkg.sv -----
// ----------------------------------------------------------------------------
// alte_pkg
// shared types, codes and sizes of the array list engine
// ----------------------------------------------------------------------------
`default_nettype none

package alte_pkg;

  // fixed field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CntW    = 8;
  localparam int unsigned RunW    = 8;
  localparam int unsigned RunStepW = 3;   // bits that address one bit of a run count
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 7;

  // defaults
  localparam int unsigned DefDepth   = 128;
  localparam logic [CntW-1:0] CapReset = 8'd100;

  // request codes
  localparam logic [OpW-1:0] OP_APPEND = 3'd0;
  localparam logic [OpW-1:0] OP_INSERT = 3'd1;
  localparam logic [OpW-1:0] OP_SORTED = 3'd2;
  localparam logic [OpW-1:0] OP_FIND   = 3'd3;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd4;
  localparam logic [OpW-1:0] OP_RUN    = 3'd5;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatusW-1:0] ST_MISSING = 2'd2;
  localparam logic [StatusW-1:0] ST_BAD     = 2'd3;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CMP,
    CMD_SCAN,
    CMD_INS,
    CMD_DEL
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e               cmd;
    logic                    sorted;
    logic signed [DataW-1:0] value;
    logic [CntW-1:0]         count;
    logic [CntW-1:0]         at;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/alte_cell.sv -----
// ----------------------------------------------------------------------------
// alte_cell
// one list entry with its compare flag and first-hit scan register
// ----------------------------------------------------------------------------
`default_nettype none

module alte_cell import alte_pkg::*; #(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 7
) (
  input  wire                          clk_i,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic signed [DataW-1:0] left_data_i,
  input  wire logic signed [DataW-1:0] far_data_i,
  input  wire logic                    part_found_i,
  input  wire logic [IdxW-1:0]         part_pos_i,
  output logic signed [DataW-1:0]      data_o,
  output logic                         found_o,
  output logic [IdxW-1:0]              pos_o
);

  logic signed [DataW-1:0] data_q, data_d;
  logic                    found_q, found_d;
  logic [IdxW-1:0]         pos_q, pos_d;
  logic                    in_list;
  logic                    hit;

  assign in_list = 32'(ctrl_i.count) > Index;
  assign hit     = in_list && (ctrl_i.sorted ? (data_q >= ctrl_i.value)
                                             : (data_q == ctrl_i.value));

  always_comb begin
    data_d  = data_q;
    found_d = found_q;
    pos_d   = pos_q;
    unique case (ctrl_i.cmd)
      CMD_CMP: begin
        found_d = hit;
        pos_d   = IdxW'(Index);
      end
      CMD_SCAN: begin
        // earlier segment wins
        if (part_found_i) begin
          found_d = 1'b1;
          pos_d   = part_pos_i;
        end
      end
      CMD_INS: begin
        if (32'(ctrl_i.at) < Index) begin
          data_d = left_data_i;
        end else if (32'(ctrl_i.at) == Index) begin
          data_d = ctrl_i.value;
        end
      end
      CMD_DEL: begin
        if (32'(ctrl_i.at) <= Index) begin
          data_d = far_data_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  assign data_o  = data_q;
  assign found_o = found_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

// ----- rtl/array_list_table_engine_unit.sv -----
// ----------------------------------------------------------------------------
// array_list_table_engine_unit
// ordered list of signed 32-bit values kept in a row of cells
// ----------------------------------------------------------------------------
// flow: compare, first-hit scan and decide states; the result is registered
//   on leaving decide, which waits while an older result is still stalled
// requests: one at a time; the next is taken only back in idle, after the
//   insert step or staged run shift that follows a successful add or remove
// reset: asynchronous, active low; length 0, capacity 100, entries undefined
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_table_engine_unit import alte_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // request channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [OpW-1:0]          op_i,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic [CntW-1:0]         position_i,
  input  wire logic [RunW-1:0]         run_count_i,
  // result channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [StatusW-1:0]           status_o,
  output logic [IndexW-1:0]            index_o,
  output logic [CntW-1:0]              length_o,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // cell address width and scan / shift step counter
  localparam int unsigned IdxW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned StepW    = ($clog2(IdxW) < RunStepW) ? RunStepW : $clog2(IdxW);
  localparam int unsigned NumSteps = 2 ** StepW;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;
  localparam logic [2:0] S_DEL    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  // latched request
  logic [OpW-1:0]          req_op_q;
  logic signed [DataW-1:0] req_value_q;
  logic [CntW-1:0]         req_pos_q;
  logic [RunW-1:0]         req_run_q;

  // list length and capacity register
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cap_q;

  // pending shift after the result is out
  logic [CntW-1:0] apply_at_q, apply_at_d;
  logic [RunW-1:0] apply_n_q, apply_n_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q;
  logic [IndexW-1:0]  index_q;
  logic [CntW-1:0]    length_q;

  logic in_accept;
  logic cfg_write;

  // cell row
  cell_ctrl_t              ctrl;
  logic signed [DataW-1:0] cell_data  [DEPTH];
  logic                    cell_found [DEPTH];
  logic [IdxW-1:0]         cell_pos   [DEPTH];

  // ------------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {24'd0, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_write) begin
      cap_q <= pwdata[CntW-1:0];
    end
  end

  // ------------------------------------------------------------------------
  // request intake
  // ------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_op_q    <= op_i;
      req_value_q <= value_i;
      req_pos_q   <= position_i;
      req_run_q   <= run_count_i;
    end
  end

  // ------------------------------------------------------------------------
  // decision once the scan has settled: the last cell holds the first hit
  // ------------------------------------------------------------------------
  logic               scan_hit;
  logic [CntW-1:0]    scan_at;
  logic               full;
  logic               run_over;
  logic [StatusW-1:0] dec_status;
  logic [CntW-1:0]    dec_idx;
  logic               dec_ins;
  logic               dec_del;
  logic [RunW-1:0]    dec_n;

  assign scan_hit = cell_found[DEPTH-1];
  assign scan_at  = CntW'(cell_pos[DEPTH-1]);
  // capacity in force is the smaller of the register and the cell count
  assign full     = (count_q >= cap_q) || (32'(count_q) >= DEPTH);
  assign run_over = ({1'b0, scan_at} + {1'b0, req_run_q}) > {1'b0, count_q};

  always_comb begin
    dec_status = ST_OK;
    dec_idx    = '0;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    dec_n      = '0;
    unique case (req_op_q)
      OP_APPEND: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_idx = count_q;
          dec_ins = 1'b1;
        end
      end
      OP_INSERT: begin
        priority if (full) begin
          dec_status = ST_FULL;
        end else if (req_pos_q > count_q) begin
          dec_status = ST_BAD;
        end else begin
          dec_idx = req_pos_q;
          dec_ins = 1'b1;
        end
      end
      OP_SORTED: begin
        // no entry at or above the value: goes at the end
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_idx = scan_hit ? scan_at : count_q;
          dec_ins = 1'b1;
        end
      end
      OP_FIND: begin
        if (!scan_hit) begin
          dec_status = ST_MISSING;
        end else begin
          dec_idx = scan_at;
        end
      end
      OP_REMOVE: begin
        if (!scan_hit) begin
          dec_status = ST_MISSING;
        end else begin
          dec_idx = scan_at;
          dec_del = 1'b1;
          dec_n   = RunW'(1);
        end
      end
      OP_RUN: begin
        priority if (!scan_hit) begin
          dec_status = ST_MISSING;
        end else if ((req_run_q == '0) || run_over) begin
          dec_status = ST_BAD;
        end else begin
          dec_idx = scan_at;
          dec_del = 1'b1;
          dec_n   = req_run_q;
        end
      end
      default: begin
        dec_status = ST_BAD;
      end
    endcase
  end

  // ------------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    apply_at_d  = apply_at_q;
    apply_n_d   = apply_n_q;
    out_valid_d = out_valid_q && out_stall_i;

    ctrl        = '0;
    ctrl.cmd    = CMD_HOLD;
    ctrl.sorted = (req_op_q == OP_SORTED);
    ctrl.value  = req_value_q;
    ctrl.count  = count_q;
    ctrl.at     = apply_at_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // every cell flags itself at once
        ctrl.cmd = CMD_CMP;
        step_d   = '0;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        // first-hit prefix, distance doubles every cycle
        ctrl.cmd = CMD_SCAN;
        if (step_q == StepW'(IdxW - 1)) begin
          step_d  = '0;
          state_d = S_DECIDE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DECIDE: begin
        // wait while an older result still sits in the output register
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          apply_at_d  = dec_idx;
          apply_n_d   = dec_n;
          step_d      = '0;
          if (dec_ins) begin
            count_d = count_q + 1'b1;
            state_d = S_INS;
          end else if (dec_del) begin
            count_d = count_q - dec_n;
            state_d = S_DEL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_INS: begin
        ctrl.cmd = CMD_INS;
        state_d  = S_IDLE;
      end
      S_DEL: begin
        // close the gap one power of two at a time
        ctrl.cmd = apply_n_q[step_q[RunStepW-1:0]] ? CMD_DEL : CMD_HOLD;
        if (step_q == StepW'(RunW - 1)) begin
          step_d  = '0;
          state_d = S_IDLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    apply_at_q <= apply_at_d;
    apply_n_q  <= apply_n_d;
    if ((state_q == S_DECIDE) && !(out_valid_q && out_stall_i)) begin
      status_q <= dec_status;
      index_q  <= (dec_status == ST_OK) ? dec_idx[IndexW-1:0] : '0;
      length_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign index_o     = index_q;
  assign length_o    = length_q;

  // ------------------------------------------------------------------------
  // row of cells with their neighbor links
  // ------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_data;
    logic signed [DataW-1:0] far_cand  [NumSteps];
    logic                    part_fcand [NumSteps];
    logic [IdxW-1:0]         part_pcand [NumSteps];

    if (i > 0) begin : g_left
      assign left_data = cell_data[i-1];
    end else begin : g_first
      assign left_data = cell_data[i];
    end

    for (genvar k = 0; k < NumSteps; k++) begin : g_step
      localparam int unsigned Dist = 1 << k;
      // shift source for the run removal
      if ((k < RunW) && (i + Dist < DEPTH)) begin : g_far
        assign far_cand[k] = cell_data[i+Dist];
      end else begin : g_far_none
        assign far_cand[k] = cell_data[i];
      end
      // scan partner on the earlier side
      if ((k < IdxW) && (i >= Dist)) begin : g_part
        assign part_fcand[k] = cell_found[i-Dist];
        assign part_pcand[k] = cell_pos[i-Dist];
      end else begin : g_part_none
        assign part_fcand[k] = 1'b0;
        assign part_pcand[k] = cell_pos[i];
      end
    end

    alte_cell #(
      .Index (i),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .left_data_i  (left_data),
      .far_data_i   (far_cand[step_q]),
      .part_found_i (part_fcand[step_q]),
      .part_pos_i   (part_pcand[step_q]),
      .data_o       (cell_data[i]),
      .found_o      (cell_found[i]),
      .pos_o        (cell_pos[i])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/alte_checker.sv -----
// ----------------------------------------------------------------------------
// alte_checker
// port-level checks of the array list engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module alte_checker import alte_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [StatusW-1:0]      status_o,
  input wire logic [IndexW-1:0]       index_o,
  input wire logic [CntW-1:0]         length_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(index_o) && $stable(length_o))
    else $error("stalled result changed");

  // failed requests report index zero
  a_fail_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> index_o == '0)
    else $error("nonzero index on failed request");

  // length never exceeds the cell count
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(length_o) <= DEPTH)
    else $error("length beyond capacity");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

endmodule

bind array_list_table_engine_unit alte_checker #(.DEPTH(DEPTH)) u_alte_checker (.*);

`default_nettype wire

// ----- dv/array_list_table_engine_unit_tb.sv -----
// ----------------------------------------------------------------------------
// array_list_table_engine_unit_tb
// checks every result of the array list engine against an in-bench list model
// ----------------------------------------------------------------------------
// requests are fed through a random-gap driver; each accepted request is run
// through a local copy of the list and the expected result is queued. a
// monitor with random stall compares status, index and length of every
// result in order. the run walks several capacity settings, including zero,
// one, full depth and a value above the depth.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_table_engine_unit_tb import alte_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH    = DefDepth;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned POOL_N        = 12;
  localparam int unsigned MAX_REPORTS   = 10;

  // register addresses on the configuration port
  localparam logic [2:0] CAPACITY_ADDR = 3'd0;

  // op codes the block does not know
  localparam logic [OpW-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;
    logic [CntW-1:0]         position;
    logic [RunW-1:0]         run_count;
  } list_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IndexW-1:0]  index;
    logic [CntW-1:0]    length;
  } list_res_t;

  // clock, reset and block ports
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [OpW-1:0]          op_i        = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic [CntW-1:0]         position_i  = '0;
  logic [RunW-1:0]         run_count_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [StatusW-1:0]      status_o;
  logic [IndexW-1:0]       index_o;
  logic [CntW-1:0]         length_o;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [2:0]              paddr       = '0;
  logic [31:0]             pwdata      = '0;
  logic [31:0]             prdata;
  logic                    pready;

  // list model: entries, length and the capacity register
  logic signed [DataW-1:0] list_mem [LIST_DEPTH];
  int unsigned             list_len = 0;
  logic [CntW-1:0]         cap_reg  = CapReset;

  // request and result bookkeeping
  list_req_t               request_q [$];
  list_res_t               result_q  [$];
  logic signed [DataW-1:0] value_pool [POOL_N];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  bit          hold_arm     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cap_writes   = 0;
  int unsigned deepest_len  = 0;
  int unsigned status_seen [4];

  array_list_table_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .run_count_i (run_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .index_o     (index_o),
    .length_o    (length_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- list model

  // first index holding the value, list_len when absent
  function automatic int unsigned first_hit(input logic signed [DataW-1:0] v);
    for (int unsigned i = 0; i < list_len; i++) begin
      if (list_mem[i] == v) return i;
    end
    return list_len;
  endfunction

  // shift entries up from slot and drop the value in
  function automatic void open_slot(input int unsigned at, input logic signed [DataW-1:0] v);
    for (int unsigned k = list_len; k > at; k--) list_mem[k] = list_mem[k-1];
    list_mem[at] = v;
    list_len++;
  endfunction

  // close a run of n entries starting at slot
  function automatic void close_run(input int unsigned at, input int unsigned n);
    for (int unsigned k = at; k + n < list_len; k++) list_mem[k] = list_mem[k+n];
    list_len -= n;
  endfunction

  // run one request on the list model and give the result it should produce
  function automatic list_res_t apply_request(input logic [OpW-1:0] op,
                                              input logic signed [DataW-1:0] v,
                                              input logic [CntW-1:0] pos,
                                              input logic [RunW-1:0] run);
    list_res_t   rs;
    int unsigned cap_now;
    int unsigned hit;
    int unsigned slot;
    bit          full;
    cap_now   = (cap_reg < LIST_DEPTH) ? cap_reg : LIST_DEPTH;
    full      = (list_len >= cap_now);
    rs.status = ST_OK;
    slot      = 0;
    case (op)
      OP_APPEND: begin
        if (full) rs.status = ST_FULL;
        else begin
          slot = list_len;
          open_slot(slot, v);
        end
      end
      OP_INSERT: begin
        if (full) rs.status = ST_FULL;
        else if (pos > list_len) rs.status = ST_BAD;
        else begin
          slot = pos;
          open_slot(slot, v);
        end
      end
      OP_SORTED: begin
        if (full) rs.status = ST_FULL;
        else begin
          // goes before the first entry that is not smaller
          while (slot < list_len && v > list_mem[slot]) slot++;
          open_slot(slot, v);
        end
      end
      OP_FIND: begin
        hit = first_hit(v);
        if (hit >= list_len) rs.status = ST_MISSING;
        else slot = hit;
      end
      OP_REMOVE: begin
        hit = first_hit(v);
        if (hit >= list_len) rs.status = ST_MISSING;
        else begin
          slot = hit;
          close_run(hit, 1);
        end
      end
      OP_RUN: begin
        // a missing value wins over a bad count
        hit = first_hit(v);
        if (hit >= list_len) rs.status = ST_MISSING;
        else if (run == 0 || hit + run > list_len) rs.status = ST_BAD;
        else begin
          slot = hit;
          close_run(hit, run);
        end
      end
      default: rs.status = ST_BAD;
    endcase
    if (rs.status != ST_OK) slot = 0;
    rs.index  = slot[IndexW-1:0];
    rs.length = list_len[CntW-1:0];
    if (list_len > deepest_len) deepest_len = list_len;
    return rs;
  endfunction

  // ---------------------------------------------------------------- driver

  // holds a request until taken, then maybe idles before the next one
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    list_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        result_q.push_back(apply_request(op_i, value_i, position_i, run_count_i));
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid_i  <= 1'b1;
          op_i        <= nxt.op;
          value_i     <= nxt.value;
          position_i  <= nxt.position;
          run_count_i <= nxt.run_count;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result side

  // random stall, plus one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // compare every taken result with the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    list_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("[%0t] unexpected result: status %0d index %0d length %0d",
                   $realtime, status_o, index_o, length_o);
      end else begin
        want = result_q.pop_front();
        checked_cnt++;
        status_seen[want.status]++;
        if (status_o !== want.status || index_o !== want.index ||
            length_o !== want.length) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] result %0d: expected status %0d index %0d length %0d, got %0d %0d %0d",
                     $realtime, checked_cnt, want.status, want.index, want.length,
                     status_o, index_o, length_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, result_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // write of the capacity register in a setup and an access phase; block must be idle
  task automatic write_capacity(input logic [CntW-1:0] cap);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {24'd0, cap};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_reg = cap;
    cap_writes++;
  endtask

  // wait until every request is taken and answered, then let the block settle
  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_request(input logic [OpW-1:0] op, input logic signed [DataW-1:0] v,
                               input logic [CntW-1:0] pos, input logic [RunW-1:0] run);
    request_q.push_back('{op: op, value: v, position: pos, run_count: run});
  endtask

  // extremes and neighbors, so finds hit and sorted inserts land in between
  task automatic refill_pool();
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int unsigned i = 4; i < POOL_N - 2; i++)
      value_pool[i] = $signed($urandom_range(0, 40)) - 20;
    value_pool[POOL_N-2] = $urandom;
    value_pool[POOL_N-1] = $urandom;
  endtask

  // random request shaped by the current list length
  function automatic list_req_t random_request(input int unsigned add_pct);
    list_req_t   rq;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    rq.value     = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, POOL_N-1)]
                                              : $urandom;
    rq.position  = CntW'($urandom_range(0, 255));
    rq.run_count = RunW'($urandom_range(0, 255));
    if (pick < add_pct) begin
      case ($urandom_range(0, 2))
        0:       rq.op = OP_APPEND;
        1:       rq.op = OP_INSERT;
        default: rq.op = OP_SORTED;
      endcase
    end else if (pick < add_pct + 4) begin
      rq.op = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
    end else begin
      case ($urandom_range(0, 2))
        0:       rq.op = OP_FIND;
        1:       rq.op = OP_REMOVE;
        default: rq.op = OP_RUN;
      endcase
    end
    if (rq.op == OP_INSERT) begin
      pick = $urandom_range(0, 9);
      if (pick < 8)       rq.position = CntW'($urandom_range(0, list_len));
      else if (pick == 8) rq.position = CntW'((list_len < 255) ? list_len + 1 : 255);
    end
    if (rq.op == OP_RUN) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       rq.run_count = RunW'($urandom_range(1, 3));
      else if (pick == 7) rq.run_count = 0;
    end
    return rq;
  endfunction

  // one random phase at a given capacity; the feeder keeps the request queue
  // short so the model length it shapes positions from stays current
  task automatic random_phase(input logic [CntW-1:0] cap, input int unsigned n_req,
                              input int unsigned add_pct);
    write_capacity(cap);
    refill_pool();
    repeat (n_req) begin
      while (request_q.size() >= 2) @(negedge clk_i);
      request_q.push_back(random_request(add_pct));
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part at the reset capacity, empty list first
    tx_idle_pct = 23;
    rx_idle_pct = 64;
    queue_request(OP_FIND,   5, 0, 0);
    queue_request(OP_REMOVE, 5, 0, 0);
    queue_request(OP_RUN,    5, 0, 1);
    queue_request(OP_APPEND, 32'sh8000_0000, 8'hff, 8'hff);
    queue_request(OP_APPEND, 32'sh7fff_ffff, 0, 0);
    queue_request(OP_APPEND, 0, 0, 0);
    queue_request(OP_APPEND, -1, 0, 0);
    queue_request(OP_INSERT, 42, 0, 0);      // at the head
    queue_request(OP_INSERT, 7, 5, 0);       // position equal to length
    queue_request(OP_INSERT, 9, 7, 0);       // position beyond length
    queue_request(OP_INSERT, 9, 8'hff, 0);
    queue_request(OP_SORTED, -1, 0, 0);
    queue_request(OP_SORTED, 32'sh8000_0000, 0, 0);
    queue_request(OP_SORTED, 32'sh7fff_ffff, 0, 0);
    queue_request(OP_FIND,   -1, 0, 0);      // first of duplicates
    queue_request(OP_REMOVE, -1, 0, 0);
    queue_request(OP_RUN,    42, 0, 0);      // zero count
    queue_request(OP_RUN,    42, 0, 8'hff);  // run past the end
    queue_request(OP_RUN,    42, 0, 2);
    queue_request(OP_UNUSED6, 0, 0, 0);
    queue_request(OP_UNUSED7, 0, 0, 0);
    drain();

    // capacity lowered below the current length: adds full, reads still work
    write_capacity(8'd2);
    queue_request(OP_APPEND, 3, 0, 0);
    queue_request(OP_INSERT, 3, 8'd200, 0);  // full is reported before position
    queue_request(OP_SORTED, 3, 0, 0);
    queue_request(OP_FIND,   32'sh7fff_ffff, 0, 0);
    queue_request(OP_RUN,    32'sh7fff_ffff, 0, 1);
    drain();

    // zero capacity: always full
    write_capacity(8'd0);
    queue_request(OP_APPEND, 11, 0, 0);
    queue_request(OP_REMOVE, 0, 0, 0);
    drain();

    // sender idles less than receiver
    random_phase(8'd128, 500, 65);   // grows to the full depth
    random_phase(8'd255, 200, 45);   // above the depth

    // receiver idles less than sender
    tx_idle_pct = 64;
    rx_idle_pct = 23;
    random_phase(8'd5, 250, 30);     // well below the length left behind
    random_phase(8'd1, 150, 50);

    // no idling; long hold-off on the result side while requests keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_arm    = 1'b1;
    random_phase(8'd40, 400, 55);
    random_phase(CntW'($urandom_range(1, 128)), 300, 50);

    mismatch_cnt += result_q.size();
    $display("covered %0d requests over %0d capacity writes, %0d results checked",
             accepted_cnt, cap_writes, checked_cnt);
    $display("status ok %0d full %0d missing %0d bad %0d, deepest list %0d entries",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_MISSING],
             status_seen[ST_BAD], deepest_len);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
